/* design/dtg_pkg.sv */
package dtg_pkg;

  // Default sizes of the sine table and the envelope fraction.
  localparam int unsigned SINE_ENTRIES_DEF  = 1024;
  localparam int unsigned ENV_FRAC_BITS_DEF = 24;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned PHASE_W      = 32;
  localparam int unsigned DECAY_W      = 24;
  localparam int unsigned AMP_W        = 15;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned CFG_W        = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned MUL_W        = 32;
  localparam int unsigned PROD_W       = 2 * MUL_W;
  localparam int unsigned SINE_FRAC_BITS = 15;

  // Sample index value that marks a finished or never started sound.
  localparam logic [LEN_W-1:0] IDLE_MARK = 16'hFFFF;

  // Quarter turn in Q31 and the series divisors (2n)(2n+1) for n = 1..7.
  localparam longint unsigned HALF_PI_Q31 = 64'd3373259426;
  localparam int unsigned SERIES_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
  localparam int unsigned SINE_PEAK = 32767;

  // Reset values of the configuration registers.
  localparam logic [PHASE_W-1:0] PHASE_STEP_A_RST = 32'd146087322;
  localparam logic [PHASE_W-1:0] PHASE_STEP_B_RST = 32'd0;
  localparam logic [DECAY_W-1:0] DECAY_RST        = 24'd16758203;
  localparam logic [AMP_W-1:0]   AMP_RST          = 15'd32767;
  localparam logic [LEN_W-1:0]   LEN_RST          = 16'd2205;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP_A   = 3'd0,
    REG_PHASE_STEP_B   = 3'd1,
    REG_SECOND_TONE_ON = 3'd2,
    REG_DECAY_FACTOR   = 3'd3,
    REG_AMPLITUDE      = 3'd4,
    REG_SOUND_LENGTH   = 3'd5
  } cfg_reg_t;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    MOP_IDX_A,
    MOP_IDX_B,
    MOP_AMP,
    MOP_ENV,
    MOP_DEC
  } mul_op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IDX_A,
    ST_IDX_B,
    ST_READ_B,
    ST_SUM,
    ST_AMP,
    ST_ENV,
    ST_SAT,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic    in_ready;
    logic    mul_en;
    mul_op_t mul_op;
    logic    latch_a;
    logic    sum_en;
    logic    sat_en;
    logic    update_en;
    logic    out_load;
  } ctrl_t;

endpackage

/* design/dtg_sine_rom.sv */
module dtg_sine_rom
  import dtg_pkg::*;
#(
  parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic [$clog2(SINE_ENTRIES)-1:0]  rd_addr,
  output logic signed [SAMPLE_W-1:0]       rd_data_r
);

  typedef logic signed [SAMPLE_W-1:0] rom_t [SINE_ENTRIES];

  // round(32767 * sin(m / N * pi / 2)) for 0 <= m <= N, by a Taylor series in Q31.
  function automatic logic [SAMPLE_W-1:0] quarter_sine(input logic [31:0] m);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    logic [SAMPLE_W-1:0] res;
    if (64'(m) * 64'd3 == 64'(SINE_ENTRIES)) begin
      res = 16'd16384;
    end else if (64'(m) >= 64'(SINE_ENTRIES)) begin
      res = SAMPLE_W'(SINE_PEAK);
    end else begin
      x    = (64'(m) * HALF_PI_Q31) / 64'(SINE_ENTRIES);
      sum  = signed'(x);
      term = x;
      for (int n = 0; n < 7; n++) begin
        term = (term * x) >> 31;
        term = (term * x) >> 31;
        term = term / 64'(SERIES_DIV[n]);
        if (n % 2 == 0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      if (sum > (64'sd1 <<< 31)) begin
        sum = 64'sd1 <<< 31;
      end
      v   = (unsigned'(sum) * 64'(SINE_PEAK) + (64'd1 << 30)) >> 31;
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

  // Full table built from the quarter wave by symmetry.
  function automatic rom_t build_rom();
    rom_t                t;
    logic [31:0]         four;
    logic [31:0]         q;
    logic [31:0]         r;
    logic [SAMPLE_W-1:0] mag;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      four = 32'(4 * k);
      q    = four / SINE_ENTRIES;
      r    = four - q * SINE_ENTRIES;
      mag  = q[0] ? quarter_sine(32'(SINE_ENTRIES) - r) : quarter_sine(r);
      t[k] = (q >= 32'd2) ? -signed'(mag) : signed'(mag);
    end
    return t;
  endfunction

  localparam rom_t ROM_DATA = build_rom();

  // Registered read, one address per cycle.
  always_ff @(posedge clk) begin
    rd_data_r <= ROM_DATA[rd_addr];
  end

endmodule

/* design/dtg_mul.sv */
module dtg_mul
  import dtg_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod_r
);

  // Unsigned 32 x 32 product, registered.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

/* design/dtg_seq.sv */
module dtg_seq
  import dtg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_accept,
  input  logic  playing,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a silent tick goes straight to the output step.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = playing ? ST_IDX_A : ST_OUT;
        end
      end
      ST_IDX_A:  state_nxt = ST_IDX_B;
      ST_IDX_B:  state_nxt = ST_READ_B;
      ST_READ_B: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_AMP;
      ST_AMP:    state_nxt = ST_ENV;
      ST_ENV:    state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Controls for each step.
  always_comb begin
    ctrl           = '0;
    ctrl.mul_op    = MOP_IDX_A;
    unique case (state_r)
      ST_IDLE:   ctrl.in_ready = 1'b1;
      ST_IDX_A: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MOP_IDX_A;
      end
      ST_IDX_B: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MOP_IDX_B;
      end
      ST_READ_B: ctrl.latch_a = 1'b1;
      ST_SUM:    ctrl.sum_en  = 1'b1;
      ST_AMP: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MOP_AMP;
      end
      ST_ENV: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MOP_ENV;
      end
      ST_SAT: begin
        ctrl.sat_en = 1'b1;
        ctrl.mul_en = 1'b1;
        ctrl.mul_op = MOP_DEC;
      end
      ST_UPDATE: ctrl.update_en = 1'b1;
      ST_OUT:    ctrl.out_load  = out_free;
      default:   ctrl.in_ready  = 1'b0;
    endcase
  end

endmodule

/* design/decaying_tone_generator.sv */
// Channel | Ports                                   | Direction
// in      | in_valid, in_stall, in_start_req        | one tick item in
// out     | out_valid, out_stall, out_sample,       | one sample item out
//         | out_active, out_last                    |
// cfg     | cfg_we, cfg_index, cfg_wdata            | register writes
//
// A playing tick passes the steps IDX_A, IDX_B, READ_B, SUM, AMP, ENV, SAT and UPDATE
// before the output step loads the output register, since one registered multiplier
// forms five products per sample in turn. A silent tick goes straight to the output step.
// A new tick is taken only in the idle step, after the last one has left the output step.
// Reset is synchronous and active low; the sound starts idle.
// A stalled output holds its item; the sequencer waits in its output step.
module decaying_tone_generator
  import dtg_pkg::*;
#(
  parameter int unsigned SINE_ENTRIES      = SINE_ENTRIES_DEF,
  parameter int unsigned ENV_FRACTION_BITS = ENV_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_start_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_active,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  localparam int unsigned IDX_W     = $clog2(SINE_ENTRIES);
  localparam int unsigned ENV_W     = ENV_FRACTION_BITS + 1;
  localparam int unsigned MAG_SHIFT = SINE_FRAC_BITS + ENV_FRACTION_BITS;

  ctrl_t ctrl;

  // Configuration registers.
  logic [PHASE_W-1:0] step_a_r;
  logic [PHASE_W-1:0] step_b_r;
  logic               tone_b_on_r;
  logic [DECAY_W-1:0] decay_r;
  logic [AMP_W-1:0]   amp_r;
  logic [LEN_W-1:0]   len_r;

  // Sound state.
  logic [LEN_W-1:0]   idx_r;
  logic [PHASE_W-1:0] phase_a_r;
  logic [PHASE_W-1:0] phase_b_r;
  logic [ENV_W-1:0]   env_r;
  logic               play_r;
  logic               last_r;

  // Datapath registers.
  logic signed [SAMPLE_W-1:0] sin_a_r;
  logic [SAMPLE_W-1:0]        abs_r;
  logic                       neg_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_active_r;
  logic                       out_last_r;

  logic                       in_accept;
  logic                       out_free;
  logic                       play_c;
  logic                       last_c;
  logic [MUL_W-1:0]           mul_a;
  logic [MUL_W-1:0]           mul_b;
  logic [PROD_W-1:0]          prod_r;
  logic signed [SAMPLE_W-1:0] rom_q;
  logic signed [SAMPLE_W:0]   sum_c;
  logic [SAMPLE_W:0]          abs_c;
  logic [PROD_W-1:0]          mag_c;
  logic signed [SAMPLE_W-1:0] sat_c;

  assign in_stall  = !ctrl.in_ready;
  assign in_accept = in_valid && ctrl.in_ready;
  assign out_free  = !out_valid_r || !out_stall;

  // The tick plays if a start is asked with a nonzero length, or the index is in range.
  assign play_c = in_start_req ? (len_r != '0) : (idx_r < len_r);
  assign last_c = ({1'b0, idx_r} + 17'd1) == {1'b0, len_r};

  dtg_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .playing   (play_c),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_a_r    <= PHASE_STEP_A_RST;
      step_b_r    <= PHASE_STEP_B_RST;
      tone_b_on_r <= 1'b0;
      decay_r     <= DECAY_RST;
      amp_r       <= AMP_RST;
      len_r       <= LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP_A:   step_a_r    <= cfg_wdata;
        REG_PHASE_STEP_B:   step_b_r    <= cfg_wdata;
        REG_SECOND_TONE_ON: tone_b_on_r <= cfg_wdata[0];
        REG_DECAY_FACTOR:   decay_r     <= cfg_wdata[DECAY_W-1:0];
        REG_AMPLITUDE:      amp_r       <= cfg_wdata[AMP_W-1:0];
        REG_SOUND_LENGTH:   len_r       <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sound state: restart on a start request, advance after a played sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= IDLE_MARK;
      phase_a_r <= '0;
      phase_b_r <= '0;
      env_r     <= ENV_W'(1) << ENV_FRACTION_BITS;
      play_r    <= 1'b0;
      last_r    <= 1'b0;
    end else if (in_accept) begin
      play_r <= play_c;
      if (in_start_req) begin
        idx_r     <= '0;
        phase_a_r <= '0;
        phase_b_r <= '0;
        env_r     <= ENV_W'(1) << ENV_FRACTION_BITS;
      end
    end else if (ctrl.update_en) begin
      last_r    <= last_c;
      idx_r     <= last_c ? IDLE_MARK : idx_r + LEN_W'(1);
      phase_a_r <= phase_a_r + step_a_r;
      phase_b_r <= phase_b_r + step_b_r;
      env_r     <= ENV_W'(prod_r >> DECAY_W);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctrl.mul_op)
      MOP_IDX_A: begin
        mul_a = phase_a_r;
        mul_b = MUL_W'(SINE_ENTRIES);
      end
      MOP_IDX_B: begin
        mul_a = phase_b_r;
        mul_b = MUL_W'(SINE_ENTRIES);
      end
      MOP_AMP: begin
        mul_a = MUL_W'(abs_r);
        mul_b = MUL_W'(amp_r);
      end
      MOP_ENV: begin
        mul_a = MUL_W'(prod_r[MUL_W-2:0]);
        mul_b = MUL_W'(env_r);
      end
      MOP_DEC: begin
        mul_a = MUL_W'(env_r);
        mul_b = MUL_W'(decay_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dtg_mul u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // The table index is the upper word of phase times the table size.
  dtg_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_rom (
    .clk       (clk),
    .rd_addr   (prod_r[MUL_W +: IDX_W]),
    .rd_data_r (rom_q)
  );

  // Sum of the two tones, split into sign and magnitude.
  assign sum_c = (SAMPLE_W + 1)'(sin_a_r)
               + (tone_b_on_r ? (SAMPLE_W + 1)'(rom_q) : '0);
  assign abs_c = sum_c[SAMPLE_W] ? unsigned'(-sum_c) : unsigned'(sum_c);

  // Scale down and saturate to 16 bits.
  assign mag_c = prod_r >> MAG_SHIFT;
  always_comb begin
    if (!neg_r) begin
      sat_c = (mag_c > PROD_W'(32767)) ? 16'sh7FFF : signed'(mag_c[SAMPLE_W-1:0]);
    end else begin
      sat_c = (mag_c > PROD_W'(32768)) ? 16'sh8000 : -signed'(mag_c[SAMPLE_W-1:0]);
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    if (ctrl.latch_a) begin
      sin_a_r <= rom_q;
    end
    if (ctrl.sum_en) begin
      abs_r <= abs_c[SAMPLE_W-1:0];
      neg_r <= sum_c[SAMPLE_W];
    end
    if (ctrl.sat_en) begin
      sample_r <= sat_c;
    end
  end

  // Output register: a silent tick gives zero with no flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_sample_r <= play_r ? sample_r : '0;
      out_active_r <= play_r;
      out_last_r   <= play_r && last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_active = out_active_r;
  assign out_last   = out_last_r;

endmodule

/* design/dtg_checker.sv */
module dtg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_sample,
  input logic        out_active,
  input logic        out_last
);

  // No item is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // The last flag only comes with a playing sample.
  a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_active)
    else $error("last flag on an idle item");

  // An idle item carries a zero sample.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_active) |-> (out_sample == 16'd0))
    else $error("nonzero sample on an idle item");

endmodule

bind decaying_tone_generator dtg_checker u_dtg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_sample (out_sample),
  .out_active (out_active),
  .out_last   (out_last)
);
